// ===== hw/rtl/ptqc_pkg.sv =====
package ptqc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int IO_WIDTH = 32;
   localparam int LIMIT_WIDTH = 63;
   localparam int MAG_WIDTH = COORD_WIDTH + 1;
   localparam int SQ_WIDTH = (MAG_WIDTH > 32) ? 32 : MAG_WIDTH;
   localparam int PROD_WIDTH = 2 * SQ_WIDTH;
   localparam int CMP_WIDTH = 65;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [IO_WIDTH-1:0] io_coord_type;
   typedef logic [LIMIT_WIDTH-1:0] limit_type;

   typedef enum logic [2:0] {
      CMD_MOVE  = 3'd0,
      CMD_LINE  = 3'd1,
      CMD_QUAD  = 3'd2,
      CMD_CLOSE = 3'd3,
      CMD_CUBIC = 3'd4,
      CMD_END   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_CURVE,
      KIND_COND,
      KIND_CUBIC
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      coord_type sx;
      coord_type sy;
      coord_type cx;
      coord_type cy;
      coord_type ex;
      coord_type ey;
   } seg_type;

   function automatic coord_type coord_in(io_coord_type raw);
      return COORD_WIDTH'(raw);
   endfunction

   function automatic coord_type half_floor(coord_type a, coord_type b);
      logic signed [COORD_WIDTH:0] s;
      s = (COORD_WIDTH + 1)'(a) + (COORD_WIDTH + 1)'(b);
      return s[COORD_WIDTH:1];
   endfunction

   function automatic coord_type min3(coord_type a, coord_type b, coord_type c);
      coord_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic coord_type max3(coord_type a, coord_type b, coord_type c);
      coord_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

endpackage

// ===== hw/rtl/ptqc_front.sv =====
module ptqc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_type,
   input  ptqc_pkg::io_coord_type req_pt_a_x,
   input  ptqc_pkg::io_coord_type req_pt_a_y,
   input  ptqc_pkg::io_coord_type req_pt_b_x,
   input  ptqc_pkg::io_coord_type req_pt_b_y,
   output logic                  push_valid,
   input  logic                  push_ready,
   output ptqc_pkg::seg_type     push_data
);
   import ptqc_pkg::*;

   coord_type cur_x_ff, cur_y_ff, sub_x_ff, sub_y_ff;
   coord_type cur_x_in, cur_y_in, sub_x_in, sub_y_in;
   logic      has_seg_ff, has_seg_in;

   coord_type ax, ay, bx, by, tx, ty;
   logic      emit, accept;

   assign req_ready = push_ready;
   assign accept = req_valid && req_ready;
   assign push_valid = req_valid && emit;

   always_comb begin
      ax = coord_in(req_pt_a_x);
      ay = coord_in(req_pt_a_y);
      bx = coord_in(req_pt_b_x);
      by = coord_in(req_pt_b_y);
      // closing target: subpath start for move and end of path, else point a
      if (req_type == CMD_MOVE || req_type == CMD_END) begin
         tx = sub_x_ff;
         ty = sub_y_ff;
      end else begin
         tx = ax;
         ty = ay;
      end
      push_data.kind = KIND_CURVE;
      push_data.sx = cur_x_ff;
      push_data.sy = cur_y_ff;
      push_data.cx = half_floor(cur_x_ff, tx);
      push_data.cy = half_floor(cur_y_ff, ty);
      push_data.ex = tx;
      push_data.ey = ty;
      emit = 1'b0;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      sub_x_in = sub_x_ff;
      sub_y_in = sub_y_ff;
      has_seg_in = has_seg_ff;
      case (req_type)
         CMD_MOVE: begin
            push_data.kind = KIND_COND;
            emit = has_seg_ff;
            cur_x_in = ax;
            cur_y_in = ay;
            sub_x_in = ax;
            sub_y_in = ay;
            has_seg_in = 1'b0;
         end
         CMD_LINE: begin
            emit = 1'b1;
            cur_x_in = ax;
            cur_y_in = ay;
            has_seg_in = 1'b1;
         end
         CMD_QUAD: begin
            push_data.cx = ax;
            push_data.cy = ay;
            push_data.ex = bx;
            push_data.ey = by;
            emit = 1'b1;
            cur_x_in = bx;
            cur_y_in = by;
            has_seg_in = 1'b1;
         end
         CMD_CLOSE: begin
            push_data.kind = KIND_COND;
            emit = 1'b1;
            cur_x_in = ax;
            cur_y_in = ay;
            has_seg_in = 1'b0;
         end
         CMD_CUBIC: begin
            push_data.kind = KIND_CUBIC;
            push_data.sx = '0;
            push_data.sy = '0;
            push_data.cx = '0;
            push_data.cy = '0;
            push_data.ex = '0;
            push_data.ey = '0;
            emit = 1'b1;
         end
         CMD_END: begin
            push_data.kind = KIND_COND;
            emit = has_seg_ff;
            cur_x_in = '0;
            cur_y_in = '0;
            sub_x_in = '0;
            sub_y_in = '0;
            has_seg_in = 1'b0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         sub_x_ff <= '0;
         sub_y_ff <= '0;
         has_seg_ff <= 1'b0;
      end else if (accept) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         sub_x_ff <= sub_x_in;
         sub_y_ff <= sub_y_in;
         has_seg_ff <= has_seg_in;
      end
   end

endmodule

// ===== hw/rtl/ptqc_queue.sv =====
module ptqc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ptqc_pkg::seg_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ptqc_pkg::seg_type pop_data
);
   import ptqc_pkg::*;

   seg_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                   push, pop;

   assign push_ready = (cnt_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ptqc_back.sv =====
module ptqc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ptqc_pkg::limit_type    limit,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  ptqc_pkg::seg_type      pop_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptqc_pkg::io_coord_type rsp_start_x,
   output ptqc_pkg::io_coord_type rsp_start_y,
   output ptqc_pkg::io_coord_type rsp_ctrl_x,
   output ptqc_pkg::io_coord_type rsp_ctrl_y,
   output ptqc_pkg::io_coord_type rsp_end_x,
   output ptqc_pkg::io_coord_type rsp_end_y,
   output ptqc_pkg::io_coord_type rsp_ext_y_min,
   output ptqc_pkg::io_coord_type rsp_ext_y_max,
   output ptqc_pkg::io_coord_type rsp_ext_x_min,
   output ptqc_pkg::io_coord_type rsp_ext_x_max,
   output logic                   rsp_cubic_error
);
   import ptqc_pkg::*;

   logic signed [MAG_WIDTH-1:0] dx, dy;
   logic [MAG_WIDTH-1:0]        mag_x, mag_y;
   logic                        s1_valid_ff;
   seg_type                     s1_seg_ff;
   logic [PROD_WIDTH-1:0]       s1_sqx_ff, s1_sqy_ff;
   logic                        s1_big_ff;
   coord_type                   s1_ymin_ff, s1_ymax_ff, s1_xmin_ff, s1_xmax_ff;
   logic [CMP_WIDTH-1:0]        sq_sum;
   logic                        coincide, keep, s2_load;
   logic                        rsp_valid_ff, rsp_valid_in;
   seg_type                     out_seg_ff;
   coord_type                   out_ymin_ff, out_ymax_ff, out_xmin_ff, out_xmax_ff;

   // stage 1: distance squares and extents
   always_comb begin
      dx = MAG_WIDTH'(pop_data.sx) - MAG_WIDTH'(pop_data.ex);
      dy = MAG_WIDTH'(pop_data.sy) - MAG_WIDTH'(pop_data.ey);
      mag_x = dx[MAG_WIDTH-1] ? $unsigned(-dx) : $unsigned(dx);
      mag_y = dy[MAG_WIDTH-1] ? $unsigned(-dy) : $unsigned(dy);
   end

   assign s2_load = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !s1_valid_ff || s2_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         s1_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         s1_seg_ff <= pop_data;
         s1_sqx_ff <= PROD_WIDTH'(mag_x[SQ_WIDTH-1:0]) * PROD_WIDTH'(mag_x[SQ_WIDTH-1:0]);
         s1_sqy_ff <= PROD_WIDTH'(mag_y[SQ_WIDTH-1:0]) * PROD_WIDTH'(mag_y[SQ_WIDTH-1:0]);
         s1_big_ff <= ((mag_x >> SQ_WIDTH) != '0) || ((mag_y >> SQ_WIDTH) != '0);
         s1_ymin_ff <= min3(pop_data.sy, pop_data.cy, pop_data.ey);
         s1_ymax_ff <= max3(pop_data.sy, pop_data.cy, pop_data.ey);
         s1_xmin_ff <= min3(pop_data.sx, pop_data.cx, pop_data.ex);
         s1_xmax_ff <= max3(pop_data.sx, pop_data.cx, pop_data.ex);
      end
   end

   // stage 2: coincidence test, output register
   always_comb begin
      sq_sum = CMP_WIDTH'(s1_sqx_ff) + CMP_WIDTH'(s1_sqy_ff);
      coincide = !s1_big_ff && (sq_sum <= CMP_WIDTH'(limit));
      keep = (s1_seg_ff.kind != KIND_COND) || !coincide;
      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = s1_valid_ff && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         out_seg_ff <= s1_seg_ff;
         out_ymin_ff <= s1_ymin_ff;
         out_ymax_ff <= s1_ymax_ff;
         out_xmin_ff <= s1_xmin_ff;
         out_xmax_ff <= s1_xmax_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_start_x = IO_WIDTH'(out_seg_ff.sx);
   assign rsp_start_y = IO_WIDTH'(out_seg_ff.sy);
   assign rsp_ctrl_x = IO_WIDTH'(out_seg_ff.cx);
   assign rsp_ctrl_y = IO_WIDTH'(out_seg_ff.cy);
   assign rsp_end_x = IO_WIDTH'(out_seg_ff.ex);
   assign rsp_end_y = IO_WIDTH'(out_seg_ff.ey);
   assign rsp_ext_y_min = IO_WIDTH'(out_ymin_ff);
   assign rsp_ext_y_max = IO_WIDTH'(out_ymax_ff);
   assign rsp_ext_x_min = IO_WIDTH'(out_xmin_ff);
   assign rsp_ext_x_max = IO_WIDTH'(out_xmax_ff);
   assign rsp_cubic_error = (out_seg_ff.kind == KIND_CUBIC);

endmodule

// ===== hw/rtl/path_to_quadratic_curves_unit.sv =====
// Path commands in, quadratic curves out.
// Request channel (req_valid/req_ready): one path command per beat, req_type
// selects move, line, quad, close, cubic or end of path; points in Q24.8.
// Response channel (rsp_valid/rsp_ready): one curve per beat with its start,
// control and end points and their x/y extents; a cubic command yields one
// beat with rsp_cubic_error set and all other fields zero.
// csr_wr_en/csr_wr_data write the coincidence limit (squared distance); write
// it only while no command is in flight.
// Throughput: one command per cycle while the queue is not full, set by the
// front state update. A curve passes the queue, then a multiply stage, then
// the compare and output register on its way to the response port.
// A four-beat queue sits between the command front and the curve back end;
// req_ready drops only when that queue is full, so a stalled receiver
// backs up into the queue and then into the request side.
// Reset clears current point, subpath start, segment flag, the limit and the
// queue; the first command after reset starts a fresh path at the origin.
module path_to_quadratic_curves_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  ptqc_pkg::limit_type    csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_type,
   input  ptqc_pkg::io_coord_type req_pt_a_x,
   input  ptqc_pkg::io_coord_type req_pt_a_y,
   input  ptqc_pkg::io_coord_type req_pt_b_x,
   input  ptqc_pkg::io_coord_type req_pt_b_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptqc_pkg::io_coord_type rsp_start_x,
   output ptqc_pkg::io_coord_type rsp_start_y,
   output ptqc_pkg::io_coord_type rsp_ctrl_x,
   output ptqc_pkg::io_coord_type rsp_ctrl_y,
   output ptqc_pkg::io_coord_type rsp_end_x,
   output ptqc_pkg::io_coord_type rsp_end_y,
   output ptqc_pkg::io_coord_type rsp_ext_y_min,
   output ptqc_pkg::io_coord_type rsp_ext_y_max,
   output ptqc_pkg::io_coord_type rsp_ext_x_min,
   output ptqc_pkg::io_coord_type rsp_ext_x_max,
   output logic                   rsp_cubic_error
);
   import ptqc_pkg::*;

   limit_type limit_ff;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   seg_type   push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   ptqc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_pt_a_x (req_pt_a_x),
      .req_pt_a_y (req_pt_a_y),
      .req_pt_b_x (req_pt_b_x),
      .req_pt_b_y (req_pt_b_y),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ptqc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ptqc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .limit           (limit_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_start_x     (rsp_start_x),
      .rsp_start_y     (rsp_start_y),
      .rsp_ctrl_x      (rsp_ctrl_x),
      .rsp_ctrl_y      (rsp_ctrl_y),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_ext_y_min   (rsp_ext_y_min),
      .rsp_ext_y_max   (rsp_ext_y_max),
      .rsp_ext_x_min   (rsp_ext_x_min),
      .rsp_ext_x_max   (rsp_ext_x_max),
      .rsp_cubic_error (rsp_cubic_error)
   );

endmodule
